>>> hdl/tgen_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgen_pkg
// Shared widths and stage counts for the triangle tangent generator.
// ----------------------------------------------------------------------------
package tgen_pkg;

  // Packed beat widths
  localparam int unsigned IN_W   = 240;  // 3 x 48 position + 3 x 32 uv
  localparam int unsigned COMP_W = 16;   // one packed component
  localparam int unsigned OUT_W  = 48;   // three Q1.14 components

  // Arithmetic widths
  localparam int unsigned DIF_W  = 17;   // edge and uv delta
  localparam int unsigned PRD_W  = 34;   // 17 x 17 product
  localparam int unsigned SUM_W  = 35;   // difference of two products
  localparam int unsigned MAG_W  = 30;   // magnitude after pre-shift
  localparam int unsigned SQ_W   = 60;   // square of a magnitude
  localparam int unsigned SS_W   = 62;   // sum of three squares
  localparam int unsigned REM_W  = 100;  // remainder of the root search

  // Result magnitude: 0..16384, one search bit per stage
  localparam int unsigned Q_W    = 15;
  localparam int unsigned NB     = 15;

  // Stages: seven front stages, search init, NB search steps, output
  localparam int unsigned FRONT  = 7;
  localparam int unsigned NST    = FRONT + 1 + NB + 1;

endpackage

>>> hdl/triangle_tangent_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_generator
// Per-triangle unit tangent from positions and uv coordinates, fully
// pipelined, one triangle per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat content
// s_*      in   tdata: pos_a, pos_b, pos_c, uv_a, uv_b, uv_c
// m_*      out  tdata: tangent_x, tangent_y, tangent_z; tuser: degenerate
//
// One triangle enters and one leaves every cycle while m_tready is high.
// Seven stages of edge, product and square math feed a search init stage, the
// 15-stage bit-serial normalization search (one result bit per stage) and output.
// rst clears all stage valid bits; payload registers are not reset.
// Each stage holds when it is full and the next stage cannot take its beat,
// so bubbles collapse and a stall drops or repeats nothing.
// ----------------------------------------------------------------------------
module triangle_tangent_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_a[47:0], pos_b[95:48], pos_c[143:96], uv_a[175:144],
  // uv_b[207:176], uv_c[239:208]
  input  logic [tgen_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // tangent_x[15:0], tangent_y[31:16], tangent_z[47:32]
  output logic [tgen_pkg::OUT_W-1:0]  m_tdata,
  // degenerate[0]
  output logic                        m_tuser
);

  localparam int unsigned NST   = tgen_pkg::NST;
  localparam int unsigned NB    = tgen_pkg::NB;
  localparam int unsigned FRONT = tgen_pkg::FRONT;
  localparam int unsigned RW    = tgen_pkg::REM_W;
  localparam int unsigned CW    = tgen_pkg::COMP_W;

  // Stage valid bits and ready chain
  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  assign rdy[NST] = m_tready;
  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_rdy
      assign rdy[g] = !vld[g] || rdy[g+1];
    end
  endgenerate
  assign s_tready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 0: edges and uv deltas
  logic signed [tgen_pkg::DIF_W-1:0] e1 [3];
  logic signed [tgen_pkg::DIF_W-1:0] e2 [3];
  logic signed [tgen_pkg::DIF_W-1:0] du1, dv1, du2, dv2;

  function automatic logic signed [tgen_pkg::DIF_W-1:0] sub16(
    input logic [CW-1:0] x, input logic [CW-1:0] y);
    sub16 = $signed({x[CW-1], x}) - $signed({y[CW-1], y});
  endfunction

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= sub16(s_tdata[48 + CW*i +: CW], s_tdata[CW*i +: CW]);
        e2[i] <= sub16(s_tdata[96 + CW*i +: CW], s_tdata[CW*i +: CW]);
      end
      du1 <= sub16(s_tdata[176 +: CW], s_tdata[144 +: CW]);
      dv1 <= sub16(s_tdata[192 +: CW], s_tdata[160 +: CW]);
      du2 <= sub16(s_tdata[208 +: CW], s_tdata[144 +: CW]);
      dv2 <= sub16(s_tdata[224 +: CW], s_tdata[160 +: CW]);
    end
  end

  // Stage 1: products
  logic signed [tgen_pkg::PRD_W-1:0] pd1, pd2;
  logic signed [tgen_pkg::PRD_W-1:0] pw1 [3];
  logic signed [tgen_pkg::PRD_W-1:0] pw2 [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pd1 <= du1 * dv2;
      pd2 <= du2 * dv1;
      for (int i = 0; i < 3; i++) begin
        pw1[i] <= dv2 * e1[i];
        pw2[i] <= dv1 * e2[i];
      end
    end
  end

  // Stage 2: determinant and raw tangent
  logic signed [tgen_pkg::SUM_W-1:0] det;
  logic signed [tgen_pkg::SUM_W-1:0] w [3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      det <= tgen_pkg::SUM_W'(pd1) - tgen_pkg::SUM_W'(pd2);
      for (int i = 0; i < 3; i++) begin
        w[i] <= tgen_pkg::SUM_W'(pw1[i]) - tgen_pkg::SUM_W'(pw2[i]);
      end
    end
  end

  // Stage 3: fold determinant sign, take magnitudes
  logic [tgen_pkg::SUM_W-1:0] mag [3];
  logic [2:0]                 sg3;
  logic                       detz;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      detz <= (det == '0);
      for (int i = 0; i < 3; i++) begin
        sg3[i] <= w[i][tgen_pkg::SUM_W-1] ^ det[tgen_pkg::SUM_W-1];
        mag[i] <= w[i][tgen_pkg::SUM_W-1] ? tgen_pkg::SUM_W'(-w[i])
                                          : tgen_pkg::SUM_W'(w[i]);
      end
    end
  end

  // Stage 4: shift all magnitudes below 2^30
  logic [tgen_pkg::SUM_W-1:0] mor;
  logic [2:0]                 shamt;
  logic [tgen_pkg::MAG_W-1:0] am [3];
  logic [2:0]                 sg4;
  logic                       dg4;

  always_comb begin
    mor = mag[0] | mag[1] | mag[2];
    if (mor[34])      shamt = 3'd5;
    else if (mor[33]) shamt = 3'd4;
    else if (mor[32]) shamt = 3'd3;
    else if (mor[31]) shamt = 3'd2;
    else if (mor[30]) shamt = 3'd1;
    else              shamt = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      dg4 <= detz || (mor == '0);
      sg4 <= sg3;
      for (int i = 0; i < 3; i++) begin
        am[i] <= tgen_pkg::MAG_W'(mag[i] >> shamt);
      end
    end
  end

  // Stage 5: squares
  logic [tgen_pkg::SQ_W-1:0] sq5 [3];
  logic [2:0]                sg5;
  logic                      dg5;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      dg5 <= dg4;
      sg5 <= sg4;
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= tgen_pkg::SQ_W'(am[i]) * tgen_pkg::SQ_W'(am[i]);
      end
    end
  end

  // Stage 6: sum of squares
  logic [tgen_pkg::SQ_W-1:0] sq6 [3];
  logic [tgen_pkg::SS_W-1:0] ss6;
  logic [2:0]                sg6;
  logic                      dg6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      dg6 <= dg5;
      sg6 <= sg5;
      sq6 <= sq5;
      ss6 <= tgen_pkg::SS_W'(sq5[0]) + tgen_pkg::SS_W'(sq5[1])
           + tgen_pkg::SS_W'(sq5[2]);
    end
  end

  // Search state: index 0 is the init stage, index j+1 after step j
  logic signed [RW-1:0]          rr  [NB+1][3];
  logic signed [RW-1:0]          ms  [NB+1][3];
  logic [tgen_pkg::Q_W-1:0]      qq  [NB+1][3];
  logic [tgen_pkg::SS_W-1:0]     sss [NB+1];
  logic [2:0]                    sgs [NB+1];
  logic                          dgs [NB+1];

  // Stage 7: remainder = 2^30 a^2 - S (for q = 0, m = -1), mS = -S
  always_ff @(posedge clk) begin
    if (rdy[FRONT]) begin
      sss[0] <= ss6;
      sgs[0] <= sg6;
      dgs[0] <= dg6;
      for (int i = 0; i < 3; i++) begin
        rr[0][i] <= $signed(RW'({sq6[i], 30'b0})) - $signed(RW'(ss6));
        ms[0][i] <= -$signed(RW'(ss6));
        qq[0][i] <= '0;
      end
    end
  end

  // Stages 8..22: decide one result bit per stage, MSB first
  generate
    for (g = 0; g < NB; g++) begin : g_step
      localparam int unsigned K = NB - 1 - g;
      logic signed [RW-1:0] sx;
      assign sx = $signed(RW'(sss[g]));
      for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [RW-1:0] tt, df;
        logic                 take;
        assign tt   = (ms[g][l] <<< (K + 2)) + (sx <<< (2*K + 2));
        assign df   = rr[g][l] - tt;
        // a set top bit already means 16384; no lower bit may follow
        assign take = !df[RW-1] && !((K < NB - 1) && qq[g][l][NB-1]);
        always_ff @(posedge clk) begin
          if (rdy[FRONT + 1 + g]) begin
            rr[g+1][l] <= take ? df : rr[g][l];
            ms[g+1][l] <= take ? ms[g][l] + (sx <<< (K + 1)) : ms[g][l];
            qq[g+1][l] <= qq[g][l] | (tgen_pkg::Q_W'(take) << K);
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[FRONT + 1 + g]) begin
          sss[g+1] <= sss[g];
          sgs[g+1] <= sgs[g];
          dgs[g+1] <= dgs[g];
        end
      end
    end
  endgenerate

  // Output stage: apply sign, force zero on degenerate triangles
  localparam int unsigned OUT_W_L = tgen_pkg::OUT_W;
  logic [OUT_W_L-1:0] odata;
  logic               odeg;

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      odeg <= dgs[NB];
      for (int i = 0; i < 3; i++) begin
        if (dgs[NB]) begin
          odata[CW*i +: CW] <= '0;
        end else if (sgs[NB][i]) begin
          odata[CW*i +: CW] <= -{1'b0, qq[NB][i]};
        end else begin
          odata[CW*i +: CW] <= {1'b0, qq[NB][i]};
        end
      end
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = odata;
  assign m_tuser  = odeg;

  // Degenerate beats carry a zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate beat with nonzero tangent");

  // Components of a good tangent stay within unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      $signed(m_tdata[15:0])  <= 16384 && $signed(m_tdata[15:0])  >= -16384 &&
      $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384 &&
      $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384)
    else $error("tangent component out of range");

  // Input only stalls when every stage is full and output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld) && !m_tready)
    else $error("input stalled with a free stage");

  // A held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

endmodule

>>> tb/sv/tb_triangle_tangent_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_generator
// Streams triangles into the tangent generator, with random gaps and
// backpressure, and checks every unit tangent against an exact integer
// predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------

class tangent_scoreboard;
  logic [48:0] expected_q[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned degenerate_seen;

  function automatic logic signed [16:0] comp(logic [15:0] v);
    return {v[15], v};
  endfunction

  // Queue one expected beat at the tail
  function automatic void add_expect(logic [48:0] v);
    expected_q.insert(expected_q.size(), v);
  endfunction

  // Largest q in 0..16384 with (2q-1)^2 * s <= 2^30 * a^2
  function automatic logic [14:0] unit_mag(logic [63:0] a, logic [63:0] s);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 0;
    hi = 16384;
    rhs = ({64'd0, a} * {64'd0, a}) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = {64'd0, (2 * mid - 1) * (2 * mid - 1)} * {64'd0, s};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  // Work out the tangent beat for one triangle
  function automatic void note_triangle(logic [239:0] d);
    logic signed [63:0] e1[3];
    logic signed [63:0] e2[3];
    logic signed [63:0] w[3];
    logic [63:0] mag[3];
    logic [63:0] big;
    logic [63:0] s;
    logic signed [63:0] ua, va, du1, dv1, du2, dv2, det;
    logic signed [15:0] q;
    logic [47:0] res;
    int sh;
    big = 0;
    s = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = comp(d[48 + 16*i +: 16]) - comp(d[16*i +: 16]);
      e2[i] = comp(d[96 + 16*i +: 16]) - comp(d[16*i +: 16]);
    end
    ua = comp(d[144 +: 16]);
    va = comp(d[160 +: 16]);
    du1 = comp(d[176 +: 16]) - ua;
    dv1 = comp(d[192 +: 16]) - va;
    du2 = comp(d[208 +: 16]) - ua;
    dv2 = comp(d[224 +: 16]) - va;
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) begin
      add_expect({1'b1, 48'd0});
      return;
    end
    for (int i = 0; i < 3; i++) begin
      w[i] = dv2 * e1[i] - dv1 * e2[i];
      if (det < 0) w[i] = -w[i];
      mag[i] = w[i] < 0 ? -w[i] : w[i];
      if (mag[i] > big) big = mag[i];
    end
    if (big == 0) begin
      add_expect({1'b1, 48'd0});
      return;
    end
    while ((big >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> sh;
      s += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      q = {1'b0, unit_mag(mag[i], s)};
      if (w[i] < 0) q = -q;
      res[16*i +: 16] = q;
    end
    add_expect({1'b0, res});
  endfunction

  // Compare one output beat with the oldest expectation
  function automatic void check_tangent(logic [47:0] data, logic degen);
    logic [48:0] e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected beat tdata=%h tuser=%b", $time, data, degen);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (degen) degenerate_seen++;
    for (int i = 0; i < 3; i++)
      if (data[16*i +: 16] !== e[16*i +: 16]) begin
        $display("%0t: tangent[%0d] expected %0d got %0d", $time, i,
                 $signed(e[16*i +: 16]), $signed(data[16*i +: 16]));
        errors++;
      end
    if (degen !== e[48]) begin
      $display("%0t: degenerate expected %b got %b", $time, e[48], degen);
      errors++;
    end
  endfunction
endclass

module tb_triangle_tangent_generator;

  localparam int LATENCY = 24;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [tgen_pkg::IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [tgen_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;

  tangent_scoreboard sb;
  bit stim_done;
  int unsigned sent;

  triangle_tangent_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one; none in mode 0
  function automatic int gap_len(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Called at a falling edge; leaves valid high after the beat is taken
  task automatic send_triangle(logic [239:0] d, int mode);
    int g;
    g = gap_len(mode);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_triangle(d);
    sent++;
    @(negedge clk);
  endtask

  // Random 16-bit component: extremes, small values, or anything
  function automatic logic [15:0] rnd_comp(int spread);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (spread == 0) return 16'($urandom_range(0, 64) - 32);
    return 16'($urandom());
  endfunction

  function automatic logic [239:0] rnd_triangle();
    logic [239:0] d;
    int spread;
    int kind;
    spread = $urandom_range(0, 3);
    for (int i = 0; i < 15; i++) d[16*i +: 16] = rnd_comp(spread);
    kind = $urandom_range(0, 19);
    // Collinear uv: zero determinant
    if (kind == 0) begin
      d[208 +: 32] = d[176 +: 32];
    end else if (kind == 1) begin
      // Degenerate positions: all vertices equal
      d[48 +: 48] = d[0 +: 48];
      d[96 +: 48] = d[0 +: 48];
    end
    return d;
  endfunction

  initial begin
    logic [239:0] d;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent = 0;
    stim_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unit axes, zero determinant, zero tangent, extremes
    d = '0;
    d[48 +: 16] = 16'h0100;   // B = (1,0,0)
    d[96 + 16 +: 16] = 16'h0100;  // C = (0,1,0)
    d[176 +: 16] = 16'h1000;  // uvB = (1,0)
    d[224 +: 16] = 16'h1000;  // uvC = (0,1)
    send_triangle(d, 0);
    d[224 +: 16] = 16'hf000;  // flipped v: negative determinant
    send_triangle(d, 0);
    d[224 +: 16] = 16'h0000;  // zero determinant
    send_triangle(d, 0);
    d = '0;
    d[176 +: 16] = 16'h1000;
    d[224 +: 16] = 16'h1000;  // zero tangent
    send_triangle(d, 0);
    d = '0;
    send_triangle(d, 0);
    d = {240{1'b1}};
    send_triangle(d, 0);
    for (int i = 0; i < 8; i++) begin
      d = '0;
      for (int k = 0; k < 15; k++) d[16*k +: 16] = (($urandom() ^ k ^ i) & 1) ?
          16'h8000 : 16'h7fff;
      send_triangle(d, 0);
    end
    for (int i = 0; i < 6; i++) begin
      d = 240'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom()});
      d = (i[0]) ? d : ~d;
      send_triangle(d, 0);
    end

    // Random triangles, bursts without gaps mixed in
    for (int i = 0; i < 2000; i++)
      send_triangle(rnd_triangle(), ((i / 200) % 3 == 0) ? 0 : 1);
    s_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Output side: random backpressure, some bursts always ready
  initial begin
    int cyc;
    m_tready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if ((cyc / 500) % 4 == 1) m_tready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_tangent(m_tdata, m_tuser);

  // Drain and report
  initial begin
    wait (stim_done);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    $display("Sent %0d triangles, checked %0d tangents (%0d degenerate).",
             sent, sb.checked, sb.degenerate_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d beats outstanding", sb.expected_q.size());
    $display("Test completed with failures");
    $finish;
  end
endmodule
